[hdl/mpsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// shared types and constants of the dictionary string matcher
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int ACTION_W = 2;
  localparam int SYM_W    = 5;
  localparam int COL_W    = 6;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  // action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_PAT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BUILD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

  typedef enum logic [1:0] {
    OP_PAT,
    OP_BUILD,
    OP_TEXT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic             last;
  } item_t;

  typedef struct packed {
    logic kind;
    logic found;
    logic full;
  } res_t;

endpackage

[hdl/mpsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_front
// input side: classifies incoming words and queues them for the engine
// ----------------------------------------------------------------------------
module mpsm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpsm_pkg::ACTION_W-1:0] action_i,
  input  logic [mpsm_pkg::SYM_W-1:0]    symbol_i,
  input  logic                          last_i,
  input  logic                          busy_i,
  output logic                          q_valid_o,
  output mpsm_pkg::item_t               q_item_o,
  input  logic                          q_pop_i
);

  mpsm_pkg::item_t ent_q [2];
  mpsm_pkg::item_t cls;
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            acc, push;

  // decode the action code
  always_comb begin
    cls.sym  = symbol_i;
    cls.last = last_i;
    case (action_i)
      mpsm_pkg::ACT_PAT:   cls.op = mpsm_pkg::OP_PAT;
      mpsm_pkg::ACT_BUILD: cls.op = mpsm_pkg::OP_BUILD;
      mpsm_pkg::ACT_TEXT:  cls.op = mpsm_pkg::OP_TEXT;
      default:             cls.op = mpsm_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = busy_i || (cnt_q == 2'd2);
  assign acc        = in_valid_i && !in_stall_o;
  // unused action codes are taken and dropped
  assign push       = acc && (cls.op != mpsm_pkg::OP_NONE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rp_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

[hdl/mpsm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_engine
// back end: trie insert, breadth-first link build and text walk
// ----------------------------------------------------------------------------
module mpsm_engine #(
  parameter int NODES    = 256,
  parameter int ALPHABET = 26
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mpsm_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            busy_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output mpsm_pkg::res_t  res_o
);

  localparam int NW = $clog2(NODES);
  localparam int TW = $clog2(NODES * ALPHABET);
  localparam int CW = mpsm_pkg::COL_W;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PAT_W, ST_PAT_UPD, ST_PAT_END,
    ST_B_INIT, ST_B_POP, ST_B_CUR, ST_B_CHW, ST_B_NXT, ST_B_FW, ST_B_FG,
    ST_B_SET, ST_B_MARK, ST_B_ADV, ST_B_DONE,
    ST_S_START, ST_S_W, ST_S_G, ST_S_MW, ST_S_HIT, ST_S_LAST, ST_RESP
  } state_e;

  // memories
  logic [NW-1:0] trie_mem [NODES*ALPHABET];
  logic [NW-1:0] fl_mem   [NODES];
  logic          mm_mem   [NODES];
  logic [NW-1:0] bq_mem   [NODES];

  state_e          st_q, st_d;
  logic [TW-1:0]   clr_q, clr_d;
  logic [NW-1:0]   ins_q, ins_d, scan_q, scan_d, tnode_q, tnode_d;
  logic [NW-1:0]   cur_q, cur_d, nxt_q, nxt_d;
  logic [NW:0]     used_q, used_d, guard_q, guard_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   col_q, col_d;
  logic            hit_q, hit_d, stale_q, stale_d, full_q, full_d;
  logic            refused_q, refused_d, is_build_q, is_build_d;
  mpsm_pkg::item_t it_q, it_d;
  mpsm_pkg::res_t  res_q, res_d;

  logic [NW-1:0]   trie_rd_q, fl_rd_q, bq_rd_q;
  logic            mm_rd_q;
  logic [TW-1:0]   trie_ra, trie_wa;
  logic [NW-1:0]   trie_wd, fl_wa, fl_wd, mm_wa, bq_wa, bq_wd;
  logic            trie_we, fl_we, mm_we, mm_wd, bq_we;
  logic            sym_ok, in_sym_ok;
  logic [NW-1:0]   g;

  assign trie_ra   = TW'(tnode_q) * TW'(ALPHABET) + TW'(col_q);
  assign sym_ok    = (7'(it_q.sym) < 7'(ALPHABET));
  assign in_sym_ok = (7'(q_item_i.sym) < 7'(ALPHABET));
  assign g         = sym_ok ? trie_rd_q : '0;

  assign busy_o      = (st_q == ST_CLEAR);
  assign res_valid_o = (st_q == ST_RESP);
  assign res_o       = res_q;

  // trie table
  always_ff @(posedge clk_i) begin
    if (trie_we) begin
      trie_mem[trie_wa] <= trie_wd;
    end
    trie_rd_q <= trie_mem[trie_ra];
  end

  // failure links
  always_ff @(posedge clk_i) begin
    if (fl_we) begin
      fl_mem[fl_wa] <= fl_wd;
    end
    fl_rd_q <= fl_mem[tnode_q];
  end

  // match marks
  always_ff @(posedge clk_i) begin
    if (mm_we) begin
      mm_mem[mm_wa] <= mm_wd;
    end
    mm_rd_q <= mm_mem[tnode_q];
  end

  // breadth-first queue
  always_ff @(posedge clk_i) begin
    if (bq_we) begin
      bq_mem[bq_wa] <= bq_wd;
    end
    bq_rd_q <= bq_mem[head_q[NW-1:0]];
  end

  // sequencer next state
  always_comb begin
    st_d = st_q;       clr_d = clr_q;     ins_d = ins_q;       scan_d = scan_q;
    tnode_d = tnode_q; cur_d = cur_q;     nxt_d = nxt_q;       used_d = used_q;
    guard_d = guard_q; head_d = head_q;   tail_d = tail_q;     col_d = col_q;
    hit_d = hit_q;     stale_d = stale_q; full_d = full_q;     refused_d = refused_q;
    is_build_d = is_build_q; it_d = it_q; res_d = res_q;
    q_pop_o = 1'b0;
    trie_we = 1'b0; trie_wa = trie_ra;  trie_wd = '0;
    fl_we   = 1'b0; fl_wa   = nxt_q;    fl_wd   = tnode_q;
    mm_we   = 1'b0; mm_wa   = nxt_q;    mm_wd   = 1'b1;
    bq_we   = 1'b0; bq_wa   = tail_q[NW-1:0]; bq_wd = nxt_q;
    case (st_q)
      // zero the trie, link and mark tables after reset
      ST_CLEAR: begin
        trie_we = 1'b1;
        trie_wa = clr_q;
        fl_we   = (clr_q < TW'(NODES));
        mm_we   = fl_we;
        fl_wa   = clr_q[NW-1:0];
        mm_wa   = clr_q[NW-1:0];
        fl_wd   = '0;
        mm_wd   = 1'b0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == TW'(NODES * ALPHABET - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          it_d    = q_item_i;
          case (q_item_i.op)
            mpsm_pkg::OP_PAT: begin
              if (!refused_q && in_sym_ok) begin
                tnode_d = ins_q;
                col_d   = CW'(q_item_i.sym);
                st_d    = ST_PAT_W;
              end else begin
                st_d = ST_PAT_END;
              end
            end
            mpsm_pkg::OP_BUILD: begin
              is_build_d = 1'b1;
              st_d       = ST_B_INIT;
            end
            mpsm_pkg::OP_TEXT: begin
              is_build_d = 1'b0;
              st_d       = stale_q ? ST_B_INIT : ST_S_START;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_PAT_W: st_d = ST_PAT_UPD;
      // follow or allocate the child, or flag the dictionary full
      ST_PAT_UPD: begin
        if (trie_rd_q == '0) begin
          if (used_q < (NW+1)'(NODES)) begin
            trie_we = 1'b1;
            trie_wd = used_q[NW-1:0];
            ins_d   = used_q[NW-1:0];
            used_d  = used_q + 1'b1;
            stale_d = 1'b1;
          end else begin
            full_d    = 1'b1;
            refused_d = 1'b1;
          end
        end else begin
          ins_d = trie_rd_q;
        end
        st_d = ST_PAT_END;
      end
      // end of pattern marks its node
      ST_PAT_END: begin
        if (it_q.last) begin
          if (!refused_q && ins_q != '0) begin
            mm_we   = 1'b1;
            mm_wa   = ins_q;
            stale_d = 1'b1;
          end
          ins_d     = '0;
          refused_d = 1'b0;
        end
        st_d = ST_IDLE;
      end
      ST_B_INIT: begin
        bq_we  = 1'b1;
        bq_wa  = '0;
        bq_wd  = '0;
        head_d = '0;
        tail_d = (NW+1)'(1);
        st_d   = ST_B_POP;
      end
      ST_B_POP: st_d = (head_q < tail_q) ? ST_B_CUR : ST_B_DONE;
      ST_B_CUR: begin
        cur_d   = bq_rd_q;
        tnode_d = bq_rd_q;
        col_d   = '0;
        head_d  = head_q + 1'b1;
        st_d    = ST_B_CHW;
      end
      ST_B_CHW: st_d = ST_B_NXT;
      // child of the current node, start of its link search
      ST_B_NXT: begin
        nxt_d = trie_rd_q;
        if (trie_rd_q == '0) begin
          st_d = ST_B_ADV;
        end else if (cur_q == '0) begin
          tnode_d = '0;
          st_d    = ST_B_SET;
        end else begin
          tnode_d = fl_rd_q;
          guard_d = '0;
          st_d    = ST_B_FW;
        end
      end
      ST_B_FW: st_d = ST_B_FG;
      // one failure step per visit
      ST_B_FG: begin
        if (tnode_q != '0 && trie_rd_q == '0 && guard_q < (NW+1)'(NODES)) begin
          tnode_d = fl_rd_q;
          guard_d = guard_q + 1'b1;
          st_d    = ST_B_FW;
        end else begin
          if (trie_rd_q != '0) begin
            tnode_d = trie_rd_q;
          end
          st_d = ST_B_SET;
        end
      end
      ST_B_SET: begin
        fl_we = 1'b1;
        if (tail_q < (NW+1)'(NODES)) begin
          bq_we  = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        st_d = ST_B_MARK;
      end
      // inherit the mark of the link target
      ST_B_MARK: begin
        mm_we = mm_rd_q;
        st_d  = ST_B_ADV;
      end
      ST_B_ADV: begin
        if (col_q == CW'(ALPHABET - 1)) begin
          st_d = ST_B_POP;
        end else begin
          col_d   = col_q + 1'b1;
          tnode_d = cur_q;
          st_d    = ST_B_CHW;
        end
      end
      ST_B_DONE: begin
        stale_d = 1'b0;
        if (is_build_q) begin
          res_d = '{kind: mpsm_pkg::KIND_BUILD, found: 1'b0, full: full_q};
          st_d  = ST_RESP;
        end else begin
          st_d = ST_S_START;
        end
      end
      ST_S_START: begin
        if (hit_q) begin
          st_d = ST_S_LAST;
        end else begin
          tnode_d = scan_q;
          col_d   = sym_ok ? CW'(it_q.sym) : '0;
          guard_d = '0;
          st_d    = ST_S_W;
        end
      end
      ST_S_W: st_d = ST_S_G;
      // text walk: goto or one failure step
      ST_S_G: begin
        if (tnode_q != '0 && g == '0 && guard_q < (NW+1)'(NODES)) begin
          tnode_d = fl_rd_q;
          guard_d = guard_q + 1'b1;
          st_d    = ST_S_W;
        end else begin
          if (g != '0) begin
            tnode_d = g;
            scan_d  = g;
          end else if (!sym_ok) begin
            tnode_d = '0;
            scan_d  = '0;
          end else begin
            scan_d = tnode_q;
          end
          st_d = ST_S_MW;
        end
      end
      ST_S_MW: st_d = ST_S_HIT;
      ST_S_HIT: begin
        if (mm_rd_q) begin
          hit_d = 1'b1;
        end
        st_d = ST_S_LAST;
      end
      ST_S_LAST: begin
        if (it_q.last) begin
          res_d  = '{kind: mpsm_pkg::KIND_TEXT, found: hit_q, full: full_q};
          scan_d = '0;
          hit_d  = 1'b0;
          st_d   = ST_RESP;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // state, control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;   clr_q <= '0;     ins_q <= '0;    scan_q <= '0;
      used_q <= (NW+1)'(1);  hit_q <= 1'b0; stale_q <= 1'b0; full_q <= 1'b0;
      refused_q <= 1'b0;  head_q <= '0;    tail_q <= '0;   guard_q <= '0;
      is_build_q <= 1'b0;
      tnode_q <= '0;      cur_q <= '0;     nxt_q <= '0;    col_q <= '0;
      it_q <= '0;         res_q <= '0;
    end else begin
      st_q <= st_d;       clr_q <= clr_d;  ins_q <= ins_d; scan_q <= scan_d;
      used_q <= used_d;   hit_q <= hit_d;  stale_q <= stale_d; full_q <= full_d;
      refused_q <= refused_d; head_q <= head_d; tail_q <= tail_d; guard_q <= guard_d;
      is_build_q <= is_build_d;
      tnode_q <= tnode_d; cur_q <= cur_d;  nxt_q <= nxt_d; col_q <= col_d;
      it_q <= it_d;       res_q <= res_d;
    end
  end

endmodule

[hdl/multi_pattern_string_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// dictionary matcher: builds a trie with failure links, scans text strings
// ----------------------------------------------------------------------------
// channel | direction | words carried
// in      | input     | action, symbol, last
// out     | output    | kind, found, dictionary_full
//
// pattern characters, text characters and build passes run as sequences of
// table reads with registered data. a pattern character that is skipped or
// refused bypasses the trie read; a text character bypasses the walk once a
// hit is seen, and the last character of a text adds the verdict step.
// after reset a clearing pass zeroes the tables; in_stall_o stays high
// meanwhile. a two-word queue decouples input from the engine; a held
// result stalls the engine, and the input as well once the queue is full.
module multi_pattern_string_matcher #(
  parameter int NODES    = 256,
  parameter int ALPHABET = 26
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpsm_pkg::ACTION_W-1:0] action_i,
  input  logic [mpsm_pkg::SYM_W-1:0]    symbol_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic                          found_o,
  output logic                          dictionary_full_o
);

  logic            busy, q_valid, q_pop, res_valid, res_ready;
  mpsm_pkg::item_t q_item;
  mpsm_pkg::res_t  res, out_q;
  logic            out_valid_q;

  mpsm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .symbol_i   (symbol_i),
    .last_i     (last_i),
    .busy_i     (busy),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mpsm_engine #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output word register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign found_o           = out_q.found;
  assign dictionary_full_o = out_q.full;

`ifndef SYNTHESIS
  // build words never report a hit
  a_build_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mpsm_pkg::KIND_BUILD) |-> !found_o)
    else $error("build word with found set");

  // no word taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("input taken while clearing");

  // a refused result stays offered unchanged
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("engine result dropped");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives pattern, build, text and unused action words into the dictionary
// matcher, predicts every verdict with its own trie model, checks results in order
// ----------------------------------------------------------------------------

// scoreboard: trie model plus ring of expected result words
class matcher_scoreboard;
  localparam int NN = 256;
  localparam int NA = 26;
  localparam int EN = 8192;

  bit [7:0]  child_tab [NN*NA];
  bit [7:0]  fail_lnk  [NN];
  bit        mark      [NN];
  int        used;
  bit [7:0]  ins_node;
  bit [7:0]  scan_pos;
  bit        hit;
  bit        stale;
  bit        full;
  bit        refused;
  bit [2:0]  exp_tab   [EN];
  int        exp_wr;
  int        exp_rd;
  int        errors;

  function new();
    used = 1;
    errors = 0;
    exp_wr = 0;
    exp_rd = 0;
  endfunction

  // expected words not yet seen
  function int pending();
    return exp_wr - exp_rd;
  endfunction

  function void add_expect(bit [2:0] e);
    exp_tab[exp_wr % EN] = e;
    exp_wr++;
  endfunction

  function bit [7:0] child(bit [7:0] n, int s);
    if (s >= NA) return '0;
    return child_tab[int'(n)*NA + s];
  endfunction

  // breadth-first failure link pass
  function void relink();
    bit [7:0] bq [NN];
    bit [7:0] cur;
    bit [7:0] nx;
    bit [7:0] f;
    int g;
    int head;
    int tail;
    bq[0] = '0;
    head = 0;
    tail = 1;
    while (head < tail) begin
      cur = bq[head];
      head++;
      for (int c = 0; c < NA; c++) begin
        nx = child(cur, c);
        if (nx == 0) continue;
        if (cur == 0) f = '0;
        else begin
          f = fail_lnk[cur];
          g = 0;
          while (f != 0 && child(f, c) == 0 && g < NN) begin
            f = fail_lnk[f];
            g++;
          end
          if (child(f, c) != 0) f = child(f, c);
        end
        fail_lnk[nx] = f;
        if (mark[f]) mark[nx] = 1'b1;
        if (tail < NN) begin
          bq[tail] = nx;
          tail++;
        end
      end
    end
    stale = 1'b0;
  endfunction

  // note one accepted input word
  function void note_word(bit [1:0] act, bit [4:0] sym, bit lst);
    bit [7:0] nx;
    bit [7:0] now;
    int g;
    if (act == mpsm_pkg::ACT_PAT) begin
      if (!refused && int'(sym) < NA) begin
        nx = child_tab[int'(ins_node)*NA + int'(sym)];
        if (nx == 0) begin
          if (used < NN) begin
            nx = used[7:0];
            used++;
            child_tab[int'(ins_node)*NA + int'(sym)] = nx;
            stale = 1'b1;
          end else begin
            full = 1'b1;
            refused = 1'b1;
          end
        end
        if (!refused) ins_node = nx;
      end
      if (lst) begin
        if (!refused && ins_node != 0) begin
          mark[ins_node] = 1'b1;
          stale = 1'b1;
        end
        ins_node = '0;
        refused = 1'b0;
      end
    end else if (act == mpsm_pkg::ACT_BUILD) begin
      relink();
      add_expect({mpsm_pkg::KIND_BUILD, 1'b0, full});
    end else if (act == mpsm_pkg::ACT_TEXT) begin
      if (stale) relink();
      if (!hit) begin
        now = scan_pos;
        g = 0;
        while (now != 0 && child(now, int'(sym)) == 0 && g < NN) begin
          now = fail_lnk[now];
          g++;
        end
        if (child(now, int'(sym)) != 0) now = child(now, int'(sym));
        else if (int'(sym) >= NA) now = '0;
        scan_pos = now;
        if (mark[now]) hit = 1'b1;
      end
      if (lst) begin
        add_expect({mpsm_pkg::KIND_TEXT, hit, full});
        scan_pos = '0;
        hit = 1'b0;
      end
    end
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // compare one result word with the oldest expectation
  task check_result(bit k, bit fd, bit fl);
    bit [2:0] e;
    if (pending() == 0) begin
      report("result with nothing expected");
      return;
    end
    e = exp_tab[exp_rd % EN];
    exp_rd++;
    if (k != e[2]) report($sformatf("kind %0d expected %0d", k, e[2]));
    if (fd != e[1]) report($sformatf("found %0d expected %0d", fd, e[1]));
    if (fl != e[0]) report($sformatf("full %0d expected %0d", fl, e[0]));
  endtask
endclass

module testbench;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] action_i;
  logic [4:0] symbol_i;
  logic       last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic       found_o;
  logic       dictionary_full_o;

  matcher_scoreboard sb;
  int  cycle_cnt;
  bit  hold_long;
  bit  hold_done;
  bit  drain_random;

  multi_pattern_string_matcher u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // random gap, mostly short, rarely long
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one word and wait until accepted
  task send_word(bit [1:0] act, bit [4:0] sym, bit lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    symbol_i <= sym;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(act, sym, lst);
  endtask

  // send a whole string of pattern or text letters
  task send_string(bit [1:0] act, int n, int maxsym);
    for (int i = 0; i < n; i++)
      send_word(act, 5'($urandom_range(0, maxsym)), i == n - 1);
  endtask

  // receiver stalls, with one long hold-off
  initial begin
    out_stall_i <= 1'b1;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!drain_random) out_stall_i <= 1'b0;
      else if ($urandom_range(0, 99) < 8) begin
        out_stall_i <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk_i);
      end else out_stall_i <= 1'b0;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(kind_o, found_o, dictionary_full_o);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 40000000) begin
      $display("multi_pattern_string_matcher verification failed");
      $finish;
    end
  end

  initial begin
    int words;
    int r;
    int n;
    sb = new();
    drain_random = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = mpsm_pkg::ACT_PAT;
    symbol_i = 5'd0;
    last_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, empty pattern, out-of-range symbols, stale build
    send_word(mpsm_pkg::ACT_PAT, 5'd0, 1'b0);
    send_word(mpsm_pkg::ACT_PAT, 5'd25, 1'b1);
    send_word(mpsm_pkg::ACT_PAT, 5'd0, 1'b1);
    send_word(mpsm_pkg::ACT_PAT, 5'd31, 1'b1);
    send_word(mpsm_pkg::ACT_PAT, 5'd26, 1'b0);
    send_word(mpsm_pkg::ACT_PAT, 5'd2, 1'b1);
    send_word(mpsm_pkg::ACT_TEXT, 5'd3, 1'b0);
    send_word(mpsm_pkg::ACT_TEXT, 5'd0, 1'b0);
    send_word(mpsm_pkg::ACT_TEXT, 5'd25, 1'b1);
    send_word(mpsm_pkg::ACT_BUILD, 5'd31, 1'b1);
    send_word(mpsm_pkg::ACT_TEXT, 5'd31, 1'b0);
    send_word(mpsm_pkg::ACT_TEXT, 5'd30, 1'b1);
    send_word(mpsm_pkg::ACT_TEXT, 5'd0, 1'b0);
    send_word(mpsm_pkg::ACT_BUILD, 5'd0, 1'b0);
    send_word(mpsm_pkg::ACT_TEXT, 5'd25, 1'b1);
    send_word(mpsm_pkg::ACT_NONE, 5'd21, 1'b1);
    send_word(mpsm_pkg::ACT_TEXT, 5'd2, 1'b1);
    send_word(mpsm_pkg::ACT_PAT, 5'd1, 1'b0);
    send_word(mpsm_pkg::ACT_PAT, 5'd0, 1'b1);
    send_word(mpsm_pkg::ACT_TEXT, 5'd1, 1'b0);
    send_word(mpsm_pkg::ACT_TEXT, 5'd0, 1'b1);

    // back pressure: receiver holds off while texts keep coming
    hold_long = 1'b1;
    for (int i = 0; i < 12; i++) send_word(mpsm_pkg::ACT_TEXT, 5'd2, 1'b1);

    // random: small alphabet so matches are common, table fills late
    words = 0;
    while (words < 1950) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        n = $urandom_range(1, 5);
        send_string(mpsm_pkg::ACT_PAT, n, $urandom_range(0, 1) ? 3 : 25);
        words += n;
      end else if (r < 36) begin
        send_word(mpsm_pkg::ACT_BUILD, 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
        words++;
      end else if (r < 96) begin
        n = $urandom_range(1, 10);
        send_string(mpsm_pkg::ACT_TEXT, n, $urandom_range(0, 1) ? 3 : 25);
        words += n;
      end else begin
        send_word(2'($urandom_range(0, 3)), 5'($urandom_range(26, 31)),
                  1'($urandom_range(0, 1)));
        words++;
      end
    end
    in_valid_i <= 1'b0;

    // drain
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
    if (sb.errors == 0) $display("multi_pattern_string_matcher verification clean");
    else $display("multi_pattern_string_matcher verification failed");
    $finish;
  end
endmodule

[filelist.f]
hdl/mpsm_pkg.sv
hdl/mpsm_front.sv
hdl/mpsm_engine.sv
hdl/multi_pattern_string_matcher.sv
tb/testbench.sv
